/* sv/tic_pkg.sv */
// shared types and constants for the timer interrupt controller
// no dependencies; used by tic_core, the top level, both checkers and the testbench

package tic_pkg;

   // item kinds carried on the request tuser
   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_READ  = 2'd1,
      MODE_WRITE = 2'd2
   } mode_type;

   localparam int NUM_VECTORS_DEF = 32;
   localparam int VEC_W           = 5;
   localparam int DATA_W          = 32;
   localparam int FLAGS_W         = 8;

   // register windows, 256 bytes each
   localparam logic [31:0] TMR_BASE = 32'h1000_0000;
   localparam logic [31:0] CTL_BASE = 32'h1000_0F00;
   localparam logic [23:0] TMR_PAGE = TMR_BASE[31:8];
   localparam logic [23:0] CTL_PAGE = CTL_BASE[31:8];

   // timer window offsets
   localparam logic [7:0] TMR_CTRL_OFF   = 8'h00;
   localparam logic [7:0] TMR_PERIOD_OFF = 8'h04;
   localparam logic [7:0] TMR_COUNT_OFF  = 8'h08;
   localparam logic [7:0] TMR_STATUS_OFF = 8'h0C;

   // controller window offsets
   localparam logic [7:0] CTL_MASK_OFF    = 8'h00;
   localparam logic [7:0] CTL_PENDING_OFF = 8'h04;
   localparam logic [7:0] CTL_EOI_OFF     = 8'h08;

   // one result beat, read_data in the low bits
   typedef struct packed {
      logic [VEC_W-1:0]  irq_vector;
      logic              irq_valid;
      logic [DATA_W-1:0] read_data;
   } rsp_type;

endpackage

/* sv/tic_core.sv */
// timer and interrupt controller state with its single-pass update logic
// depends on tic_pkg

module tic_core #(
   parameter int NUM_VECTORS = tic_pkg::NUM_VECTORS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [1:0]              mode,
   input  logic [31:0]             addr,
   input  logic [31:0]             wdata,
   output tic_pkg::rsp_type        rsp
);

   localparam logic [31:0] VEC_MASK = 32'((64'd1 << NUM_VECTORS) - 64'd1);
   localparam logic [7:0]  VEC_LIMIT = 8'(NUM_VECTORS);

   logic                              timer_on_ff,     timer_on_in;
   logic                              timer_irq_on_ff, timer_irq_on_in;
   logic [tic_pkg::DATA_W-1:0]        timer_reload_ff, timer_reload_in;
   logic [tic_pkg::DATA_W-1:0]        timer_value_ff,  timer_value_in;
   logic [tic_pkg::FLAGS_W-1:0]       timer_flags_ff,  timer_flags_in;
   logic [31:0]                       irq_mask_ff,     irq_mask_in;
   logic [31:0]                       irq_pending_ff,  irq_pending_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_on_ff     <= 1'b0;
         timer_irq_on_ff <= 1'b0;
         timer_reload_ff <= '0;
         timer_value_ff  <= '0;
         timer_flags_ff  <= '0;
         irq_mask_ff     <= '0;
         irq_pending_ff  <= '0;
      end else if (step) begin
         timer_on_ff     <= timer_on_in;
         timer_irq_on_ff <= timer_irq_on_in;
         timer_reload_ff <= timer_reload_in;
         timer_value_ff  <= timer_value_in;
         timer_flags_ff  <= timer_flags_in;
         irq_mask_ff     <= irq_mask_in;
         irq_pending_ff  <= irq_pending_in;
      end
   end

   always_comb begin
      logic                  in_tmr;
      logic                  in_ctl;
      logic [7:0]            off;
      logic [7:0]            eoi_vec;
      logic [31:0]           live;
      logic [31:0]           rd;
      logic [tic_pkg::VEC_W-1:0] vec;

      timer_on_in     = timer_on_ff;
      timer_irq_on_in = timer_irq_on_ff;
      timer_reload_in = timer_reload_ff;
      timer_value_in  = timer_value_ff;
      timer_flags_in  = timer_flags_ff;
      irq_mask_in     = irq_mask_ff;
      irq_pending_in  = irq_pending_ff;

      in_tmr  = (addr[31:8] == tic_pkg::TMR_PAGE);
      in_ctl  = (addr[31:8] == tic_pkg::CTL_PAGE);
      off     = addr[7:0];
      eoi_vec = wdata[7:0];
      rd      = '0;

      case (mode)
         tic_pkg::MODE_TICK: begin
            if (timer_on_ff && (timer_reload_ff != '0)) begin
               if (timer_value_ff == '0) begin
                  // period elapsed: flag, raise vector 0 if the timer interrupt is on, reload
                  timer_flags_in = 8'd1;
                  if (timer_irq_on_ff) begin
                     irq_pending_in = irq_pending_ff | 32'd1;
                  end
                  timer_value_in = timer_reload_ff;
               end else begin
                  timer_value_in = timer_value_ff - 32'd1;
               end
            end
         end
         tic_pkg::MODE_READ: begin
            if (in_tmr) begin
               case (off)
                  tic_pkg::TMR_CTRL_OFF:   rd = {30'd0, timer_irq_on_ff, timer_on_ff};
                  tic_pkg::TMR_PERIOD_OFF: rd = timer_reload_ff;
                  tic_pkg::TMR_COUNT_OFF:  rd = timer_value_ff;
                  tic_pkg::TMR_STATUS_OFF: rd = {24'd0, timer_flags_ff};
                  default:                 rd = '0;
               endcase
            end else if (in_ctl) begin
               case (off)
                  tic_pkg::CTL_MASK_OFF:    rd = irq_mask_ff;
                  tic_pkg::CTL_PENDING_OFF: rd = irq_pending_ff;
                  default:                  rd = '0;
               endcase
            end
         end
         tic_pkg::MODE_WRITE: begin
            if (in_tmr) begin
               case (off)
                  tic_pkg::TMR_CTRL_OFF: begin
                     timer_on_in     = wdata[0];
                     timer_irq_on_in = wdata[1];
                  end
                  tic_pkg::TMR_PERIOD_OFF: timer_reload_in = wdata;
                  tic_pkg::TMR_COUNT_OFF:  timer_value_in  = wdata;
                  tic_pkg::TMR_STATUS_OFF: timer_flags_in  = wdata[7:0];
                  default: ;
               endcase
            end else if (in_ctl) begin
               case (off)
                  tic_pkg::CTL_MASK_OFF:    irq_mask_in    = wdata;
                  tic_pkg::CTL_PENDING_OFF: irq_pending_in = irq_pending_ff & ~wdata;
                  tic_pkg::CTL_EOI_OFF: begin
                     if (eoi_vec < VEC_LIMIT) begin
                        irq_pending_in = irq_pending_ff & ~(32'd1 << eoi_vec[4:0]);
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase

      // lowest pending unmasked vector, seen after this item
      live = irq_pending_in & ~irq_mask_in & VEC_MASK;
      vec  = '0;
      for (int i = 31; i >= 0; i--) begin
         if (live[i]) begin
            vec = tic_pkg::VEC_W'(i);
         end
      end

      rsp.read_data  = rd;
      rsp.irq_valid  = |live;
      rsp.irq_vector = vec;
   end

endmodule

/* sv/timer_interrupt_controller_top.sv */
// top level of the timer interrupt controller: stream ports, input stage, result register
// depends on tic_pkg and tic_core
//
//   channel  | direction | ports                        | beat contents
//   ---------+-----------+------------------------------+------------------------------------
//   req      | in        | req_tvalid/tready/tdata/tuser| tuser: mode; tdata: addr, write_data
//   rsp      | out       | rsp_tvalid/tready/tdata      | read_data, irq_valid, irq_vector
//
// one request beat is taken every cycle while the result side keeps up
// a result beat is offered from the result register: the input stage holds the request
// beat while the single register update pass in tic_core works on it and loads the
// result register once that register is free
// the input stage and the result register each hold one beat, so a stalled
// result still lets one more request in; backpressure reaches req_tready from there
// reset clears every timer and controller register and empties both stages

module timer_interrupt_controller_top #(
   parameter int NUM_VECTORS = tic_pkg::NUM_VECTORS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] addr, [63:32] write_data
   input  logic [1:0]  req_tuser,   // [1:0] mode
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] read_data, [32] irq_valid, [37:33] irq_vector
);

   // input stage
   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_mode_ff,  s1_mode_in;
   logic [31:0] s1_addr_ff,  s1_addr_in;
   logic [31:0] s1_wdata_ff, s1_wdata_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   tic_pkg::rsp_type rsp_data_ff,  rsp_data_in;

   tic_pkg::rsp_type core_rsp;
   logic             out_free;
   logic             s1_fire;
   logic             req_fire;

   // result slot frees when empty or being taken this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   // state moves only when the held beat is committed to the result register
   tic_core #(
      .NUM_VECTORS (NUM_VECTORS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (s1_fire),
      .mode  (s1_mode_ff),
      .addr  (s1_addr_ff),
      .wdata (s1_wdata_ff),
      .rsp   (core_rsp)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_mode_in  = s1_mode_ff;
      s1_addr_in  = s1_addr_ff;
      s1_wdata_in = s1_wdata_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_mode_in  = req_tuser;
         s1_addr_in  = req_tdata[31:0];
         s1_wdata_in = req_tdata[63:32];
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_rsp;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      s1_mode_ff  <= s1_mode_in;
      s1_addr_ff  <= s1_addr_in;
      s1_wdata_ff <= s1_wdata_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};

endmodule

/* sv/tic_checker.sv */
// port-level checks for the timer interrupt controller, bound to the top level
// depends on tic_pkg and timer_interrupt_controller_top

module tic_checker #(
   parameter int NUM_VECTORS = tic_pkg::NUM_VECTORS_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result beat changed while stalled");

   // no interrupt means vector reads as zero
   a_vec_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[32]) |-> (rsp_tdata[37:33] == 5'd0))
      else $error("vector nonzero without a pending interrupt");

   // reported vector lies within the implemented lines
   a_vec_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[37:33]) < 32'(NUM_VECTORS)))
      else $error("vector beyond implemented lines");

   // an empty result register never stalls requests
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with no result waiting");

endmodule

bind timer_interrupt_controller_top tic_checker #(
   .NUM_VECTORS (NUM_VECTORS)
) u_tic_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* dv/tic_checker.sv */
// result checker for the timer interrupt controller: watches both stream channels,
// keeps its own copy of the timer and controller registers and compares each result beat
// depends on tic_pkg
`timescale 1ns / 1ps

module tic_result_checker
   import tic_pkg::*;
#(
   parameter int NUM_VECTORS = NUM_VECTORS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] addr, [63:32] write_data
   input  logic [1:0]  req_tuser,   // [1:0] mode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [31:0] read_data, [32] irq_valid, [37:33] irq_vector
   output int          mismatch_count,
   output int          expected_left,
   output int          results_seen
);

   // vectors that can ever be reported
   localparam logic [31:0] VEC_SPAN = (NUM_VECTORS >= 32) ? 32'hFFFF_FFFF :
                                      ((32'd1 << NUM_VECTORS) - 32'd1);

   rsp_type     result_fifo [$];

   logic        tmr_on;
   logic        tmr_irq_on;
   logic [31:0] tmr_period;
   logic [31:0] tmr_count;
   logic [7:0]  tmr_status;
   logic [31:0] irq_mask;
   logic [31:0] irq_pend;
   int          mismatches;
   int          seen;

   // applies one request to the register copy and returns the result beat it gives
   function automatic rsp_type next_result(logic [1:0] kind, logic [31:0] addr,
                                           logic [31:0] wdata);
      rsp_type     r;
      logic [31:0] live;
      logic [7:0]  eoi_vec;
      r = '0;
      eoi_vec = wdata[7:0];
      case (kind)
         MODE_TICK: begin
            if (tmr_on && tmr_period != 32'd0) begin
               if (tmr_count == 32'd0) begin
                  tmr_status = 8'd1;
                  if (tmr_irq_on)
                     irq_pend[0] = 1'b1;
                  tmr_count = tmr_period;
               end else begin
                  tmr_count = tmr_count - 32'd1;
               end
            end
         end
         MODE_READ: begin
            if (addr[31:8] == TMR_PAGE) begin
               case (addr[7:0])
                  TMR_CTRL_OFF:   r.read_data = {30'd0, tmr_irq_on, tmr_on};
                  TMR_PERIOD_OFF: r.read_data = tmr_period;
                  TMR_COUNT_OFF:  r.read_data = tmr_count;
                  TMR_STATUS_OFF: r.read_data = {24'd0, tmr_status};
                  default:        r.read_data = 32'd0;
               endcase
            end else if (addr[31:8] == CTL_PAGE) begin
               case (addr[7:0])
                  CTL_MASK_OFF:    r.read_data = irq_mask;
                  CTL_PENDING_OFF: r.read_data = irq_pend;
                  default:         r.read_data = 32'd0;
               endcase
            end
         end
         MODE_WRITE: begin
            if (addr[31:8] == TMR_PAGE) begin
               case (addr[7:0])
                  TMR_CTRL_OFF: begin
                     tmr_on     = wdata[0];
                     tmr_irq_on = wdata[1];
                  end
                  TMR_PERIOD_OFF: tmr_period = wdata;
                  TMR_COUNT_OFF:  tmr_count  = wdata;
                  TMR_STATUS_OFF: tmr_status = wdata[7:0];
                  default: ;
               endcase
            end else if (addr[31:8] == CTL_PAGE) begin
               case (addr[7:0])
                  CTL_MASK_OFF:    irq_mask = wdata;
                  CTL_PENDING_OFF: irq_pend = irq_pend & ~wdata;
                  CTL_EOI_OFF: begin
                     if (eoi_vec < NUM_VECTORS)
                        irq_pend[eoi_vec[4:0]] = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
      live = irq_pend & ~irq_mask & VEC_SPAN;
      r.irq_valid = |live;
      for (int i = 31; i >= 0; i--)
         if (live[i])
            r.irq_vector = i[VEC_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         tmr_on     = 1'b0;
         tmr_irq_on = 1'b0;
         tmr_period = 32'd0;
         tmr_count  = 32'd0;
         tmr_status = 8'd0;
         irq_mask   = 32'd0;
         irq_pend   = 32'd0;
         mismatches = 0;
         seen       = 0;
         result_fifo.delete();
      end else begin
         // results leave before this edge's request is predicted
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(rsp_type)-1:0];
            seen++;
            if (result_fifo.size() == 0) begin
               $display("%0t: result beat with nothing expected, got %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = result_fifo.pop_front();
               if (got.read_data !== want.read_data) begin
                  $display("%0t: read_data expected %h, got %h",
                           $time, want.read_data, got.read_data);
                  mismatches++;
               end
               if (got.irq_valid !== want.irq_valid) begin
                  $display("%0t: irq_valid expected %b, got %b",
                           $time, want.irq_valid, got.irq_valid);
                  mismatches++;
               end
               if (got.irq_vector !== want.irq_vector) begin
                  $display("%0t: irq_vector expected %0d, got %0d",
                           $time, want.irq_vector, got.irq_vector);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready)
            result_fifo.push_back(next_result(req_tuser, req_tdata[31:0], req_tdata[63:32]));
      end
      mismatch_count <= mismatches;
      expected_left  <= result_fifo.size();
      results_seen   <= seen;
   end

endmodule

/* dv/tb.sv */
// testbench top for the timer interrupt controller: clock, reset, request stimulus,
// result back-pressure and the verdict; prediction and comparison live in tic_result_checker
// depends on tic_pkg, tic_result_checker and timer_interrupt_controller_top
`timescale 1ns / 1ps

module tb;
   import tic_pkg::*;

   // the mode code the block has no meaning for
   localparam logic [1:0] MODE_SPARE = 2'd3;

   // full register addresses
   localparam logic [31:0] ADDR_CTRL    = {TMR_PAGE, TMR_CTRL_OFF};
   localparam logic [31:0] ADDR_PERIOD  = {TMR_PAGE, TMR_PERIOD_OFF};
   localparam logic [31:0] ADDR_COUNT   = {TMR_PAGE, TMR_COUNT_OFF};
   localparam logic [31:0] ADDR_STATUS  = {TMR_PAGE, TMR_STATUS_OFF};
   localparam logic [31:0] ADDR_MASK    = {CTL_PAGE, CTL_MASK_OFF};
   localparam logic [31:0] ADDR_PENDING = {CTL_PAGE, CTL_PENDING_OFF};
   localparam logic [31:0] ADDR_EOI     = {CTL_PAGE, CTL_EOI_OFF};

   // control register bits
   localparam logic [31:0] CTRL_RUN = 32'h1;
   localparam logic [31:0] CTRL_IRQ = 32'h2;

   localparam int RANDOM_PER_PHASE = 200;
   localparam int LONG_STALL       = 60;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   int          mismatches;
   int          expected_left;
   int          results_seen;
   int          beats_sent   = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   bit          stall_armed  = 1'b0;
   bit          stall_done   = 1'b0;

   always #1 clock = ~clock;

   timer_interrupt_controller_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   tic_result_checker chk (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatches),
      .expected_left  (expected_left),
      .results_seen   (results_seen)
   );

   // offers one request beat and returns once it has been taken
   // called just after a rising edge, so every drive here lands on an edge
   task automatic issue_beat(logic [1:0] kind, logic [31:0] addr, logic [31:0] wdata);
      // random idle cycles ahead of the beat
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {wdata, addr};
      @(posedge clock);
      // tready read here is the value the edge just sampled
      while (!req_tready)
         @(posedge clock);
      beats_sent++;
   endtask

   function automatic logic [31:0] reg_addr(int unsigned idx);
      case (idx)
         0:       return ADDR_CTRL;
         1:       return ADDR_PERIOD;
         2:       return ADDR_COUNT;
         3:       return ADDR_STATUS;
         4:       return ADDR_MASK;
         5:       return ADDR_PENDING;
         default: return ADDR_EOI;
      endcase
   endfunction

   // one random beat, weighted towards traffic that makes the timer fire:
   // short periods and counts, timer mostly enabled, vector 0 mostly unmasked
   task automatic random_beat();
      int unsigned pick;
      int unsigned idx;
      logic [31:0] a;
      logic [31:0] d;
      pick = $urandom_range(99);
      d = $urandom;
      if (pick < 35) begin
         issue_beat(MODE_TICK, $urandom, d);
      end else if (pick < 58) begin
         issue_beat(MODE_READ, reg_addr($urandom_range(6)), d);
      end else if (pick < 85) begin
         idx = $urandom_range(6);
         case (idx)
            0: d[0] = ($urandom_range(4) != 0);
            1, 2: begin
               if ($urandom_range(4) != 0)
                  d = $urandom_range(6);
            end
            4: begin
               if ($urandom_range(1) != 0)
                  d[0] = 1'b0;
            end
            6: begin
               if ($urandom_range(3) != 0)
                  d[7:0] = 8'($urandom_range(40));
            end
            default: ;
         endcase
         issue_beat(MODE_WRITE, reg_addr(idx), d);
      end else if (pick < 95) begin
         // addresses around and outside the two windows
         case ($urandom_range(3))
            0:       a = $urandom;
            1:       a = {TMR_PAGE, 8'($urandom)};
            2:       a = {CTL_PAGE, 8'($urandom)};
            default: a = reg_addr($urandom_range(6)) | 32'($urandom_range(1, 3));
         endcase
         issue_beat($urandom_range(1) ? MODE_WRITE : MODE_READ, a, d);
      end else begin
         issue_beat(MODE_SPARE, $urandom, d);
      end
   endtask

   // result side: random tready, plus one long hold-off once armed
   initial begin : result_sink
      forever begin
         @(posedge clock);
         if (stall_armed && !stall_done) begin
            rsp_tready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
            stall_done = 1'b1;
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // hard stop well beyond the slowest plausible run
   initial begin : watchdog
      #400000;
      $display("timeout with %0d results still expected", expected_left);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: reset values, timer off, zero period
      issue_beat(MODE_READ,  ADDR_CTRL, 32'd0);
      issue_beat(MODE_TICK,  32'd0, 32'd0);
      issue_beat(MODE_WRITE, ADDR_CTRL, CTRL_RUN | CTRL_IRQ);
      issue_beat(MODE_TICK,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // period 2: first tick fires from count 0, then counts down and fires again
      issue_beat(MODE_WRITE, ADDR_PERIOD, 32'd2);
      issue_beat(MODE_TICK,  32'd0, 32'd0);
      issue_beat(MODE_READ,  ADDR_STATUS, 32'd0);
      issue_beat(MODE_TICK,  32'd0, 32'd0);
      issue_beat(MODE_READ,  ADDR_COUNT, 32'd0);
      issue_beat(MODE_TICK,  32'd0, 32'd0);
      issue_beat(MODE_TICK,  32'd0, 32'd0);
      // masking hides the pending line, write-one-to-clear removes it
      issue_beat(MODE_WRITE, ADDR_MASK, 32'hFFFF_FFFF);
      issue_beat(MODE_READ,  ADDR_PENDING, 32'd0);
      issue_beat(MODE_WRITE, ADDR_MASK, 32'd0);
      issue_beat(MODE_WRITE, ADDR_PENDING, 32'hFFFF_FFFF);
      // status keeps only its low byte; full-width period and count
      issue_beat(MODE_WRITE, ADDR_STATUS, 32'hFFFF_FFFF);
      issue_beat(MODE_READ,  ADDR_STATUS, 32'd0);
      issue_beat(MODE_WRITE, ADDR_PERIOD, 32'hFFFF_FFFF);
      issue_beat(MODE_WRITE, ADDR_COUNT, 32'd0);
      issue_beat(MODE_TICK,  32'd0, 32'd0);
      // end-of-interrupt: out-of-range vector does nothing, vector 0 clears
      issue_beat(MODE_WRITE, ADDR_EOI, 32'd32);
      issue_beat(MODE_READ,  ADDR_EOI, 32'd0);
      issue_beat(MODE_WRITE, ADDR_EOI, 32'hFFFF_FF00);
      // unmapped: misaligned, controller offset 0x0C, far away, spare mode
      issue_beat(MODE_READ,  ADDR_STATUS | 32'd1, 32'd0);
      issue_beat(MODE_WRITE, {CTL_PAGE, 8'h0C}, 32'hFFFF_FFFF);
      issue_beat(MODE_READ,  32'hFFFF_FFFF, 32'd0);
      issue_beat(MODE_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // random: sender rarely idles, receiver often stalls
      send_idle_pct = 9;
      recv_idle_pct = 66;
      repeat (RANDOM_PER_PHASE) random_beat();

      // random: the other way round
      send_idle_pct = 66;
      recv_idle_pct = 9;
      repeat (RANDOM_PER_PHASE) random_beat();

      // random at full rate, opened by one long result hold-off so the block backs up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_armed = 1'b1;
      repeat (RANDOM_PER_PHASE) random_beat();

      req_tvalid <= 1'b0;
      do
         @(posedge clock);
      while (expected_left != 0);
      // let any stray beat show up
      repeat (8) @(posedge clock);

      $display("sent %0d request beats (ticks, reads, writes, unmapped and spare modes)",
               beats_sent);
      $display("checked %0d result beats across three idle mixes and a %0d-cycle hold-off",
               results_seen, LONG_STALL);
      if (mismatches == 0 && expected_left == 0 && stall_done) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
